### rtl/core/piecewise_linear_gain_correction_macros.svh
// Assertion macros used by the gain correction controller
`ifndef PIECEWISE_LINEAR_GAIN_CORRECTION_MACROS_SVH
`define PIECEWISE_LINEAR_GAIN_CORRECTION_MACROS_SVH

// Check an implication on every rising clock edge out of reset
`define PLGC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds out of reset
`define PLGC_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### rtl/core/plgc_pkg.sv
// Types, constants and helpers for the gain correction block
package plgc_pkg;

	localparam int NUM_POINTS = 64;
	localparam int NUM_AXES   = 3;
	localparam int TBL_DEPTH  = NUM_AXES * NUM_POINTS;
	localparam int ADDR_W     = $clog2(TBL_DEPTH);
	localparam int IDX_W      = $clog2(NUM_POINTS);
	localparam int CNT_W      = $clog2(NUM_POINTS + 1);
	localparam int ENTRY_W    = 64;
	localparam int MUL_STEPS  = 33;
	localparam int DIV_STEPS  = 66;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	localparam logic       OP_LOAD    = 1'b0;
	localparam logic       OP_CORRECT = 1'b1;
	localparam logic [1:0] AXIS_Z     = 2'd2;

	typedef struct packed {
		logic               operation;
		logic [1:0]         axis;
		logic [5:0]         point_index;
		logic signed [31:0] breakpoint_field;
		logic signed [31:0] breakpoint_correction;
		logic signed [31:0] sample_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] corrected_value;
		logic               extrapolated;
		logic               saturated;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] field;
		logic signed [31:0] corr;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic             wr_en;
		logic             start;
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
		logic             take_prev;
		logic             take_e0;
		logic             take_e1;
		logic             set_seg;
		logic             seg_first;
		logic             e1_live;
		logic             mul_load_interp;
		logic             mul_load_gain;
		logic             mul_step;
		logic             div_load;
		logic             div_step;
		logic             corr_from_div;
		logic             corr_direct;
		logic             out_load;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic seg_hit;
		logic below_first;
		logic den_zero;
	} dp_stat_t;

	function automatic logic [ADDR_W-1:0] tbl_addr(input logic [1:0] axis,
			input logic [IDX_W-1:0] idx);
		return ADDR_W'(axis) * ADDR_W'(NUM_POINTS) + ADDR_W'(idx);
	endfunction

endpackage

### rtl/core/plgc_ram.sv
// Generic single write port RAM with registered read
module plgc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and read one address each per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/plgc_dp.sv
// Datapath: curve memory, segment registers, serial multiplier and divider
module plgc_dp (
	input  logic                clk,
	input  plgc_pkg::in_item_t  in_item,
	input  plgc_pkg::ctl_cmd_t  cmd,
	output plgc_pkg::dp_stat_t  stat,
	output plgc_pkg::out_item_t out_item
);
	import plgc_pkg::*;

	logic [ENTRY_W-1:0] rdata;
	entry_t             e;
	entry_t             prev_q, e0_q, e1_q, lft_q, rgt_q;
	logic signed [31:0] samp_q;
	logic [1:0]         axis_q;
	logic               extra_q, neg_q, sat_q;
	logic signed [31:0] corr_q;
	logic [32:0]        mcand_q, dvs_q, rem_q;
	logic [66:0]        p_q;
	logic [65:0]        quo_q;
	out_item_t          out_q;

	logic signed [32:0] num, dc, den;
	logic [33:0]        msum, rs;
	logic [40:0]        qcap;
	logic signed [42:0] corr_w;
	logic signed [33:0] gain;
	logic [33:0]        gmag;
	logic [63:0]        rsum;
	logic [33:0]        rnd;

	function automatic logic [32:0] mag33(input logic signed [32:0] v);
		return v[32] ? 33'(-v) : 33'(v);
	endfunction

	plgc_ram #(.WIDTH(ENTRY_W), .DEPTH(TBL_DEPTH)) u_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (tbl_addr(in_item.axis, IDX_W'(in_item.point_index))),
		.wdata ({in_item.breakpoint_field, in_item.breakpoint_correction}),
		.re    (cmd.rd_en),
		.raddr (tbl_addr(axis_q, cmd.rd_idx)),
		.rdata (rdata)
	);

	// Segment arithmetic and status
	always_comb begin
		e    = entry_t'(rdata);
		num  = {samp_q[31], samp_q} - {lft_q.field[31], lft_q.field};
		dc   = {rgt_q.corr[31], rgt_q.corr} - {lft_q.corr[31], lft_q.corr};
		den  = {rgt_q.field[31], rgt_q.field} - {lft_q.field[31], lft_q.field};
		stat.seg_hit     = ($signed(prev_q.field) <= samp_q) && (samp_q <= $signed(e.field));
		stat.below_first = samp_q < $signed(e0_q.field);
		stat.den_zero    = (den == 33'sd0);
		msum = p_q[66:33] + (p_q[0] ? {1'b0, mcand_q} : 34'd0);
		rs   = {rem_q, p_q[65]};
		qcap = ((|quo_q[65:41]) || (quo_q[40] && (|quo_q[39:0])))
			? {1'b1, 40'd0} : quo_q[40:0];
		corr_w = neg_q ? 43'(lft_q.corr) - $signed({2'b0, qcap})
			: 43'(lft_q.corr) + $signed({2'b0, qcap});
		gain = 34'sh4000_0000 + 34'(corr_q);
		gmag = gain[33] ? 34'(-gain) : 34'(gain);
		rsum = p_q[63:0] + 64'h2000_0000;
		rnd  = rsum[63:30];
	end

	// Capture the sample and walk the curve
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			samp_q <= in_item.sample_value;
			axis_q <= in_item.axis;
		end
		if (cmd.take_prev) begin
			prev_q <= e;
		end
		if (cmd.take_e0) begin
			e0_q <= e;
		end
		if (cmd.take_e1) begin
			e1_q <= e;
		end
		if (cmd.set_seg) begin
			extra_q <= !stat.seg_hit;
			if (cmd.seg_first) begin
				lft_q <= e0_q;
				rgt_q <= cmd.e1_live ? e : e1_q;
			end else begin
				lft_q <= prev_q;
				rgt_q <= e;
			end
		end
	end

	// Shared shift-add multiplier and restoring divider
	always_ff @(posedge clk) begin
		if (cmd.mul_load_interp) begin
			mcand_q <= mag33(num);
			p_q     <= {34'd0, mag33(dc)};
			dvs_q   <= mag33(den);
			neg_q   <= num[32] ^ dc[32] ^ den[32];
		end else if (cmd.mul_load_gain) begin
			mcand_q <= mag33({samp_q[31], samp_q});
			p_q     <= {34'd0, gmag[32:0]};
			neg_q   <= samp_q[31] ^ gain[33] ^ (axis_q != AXIS_Z);
		end else if (cmd.mul_step) begin
			p_q <= {1'b0, msum, p_q[32:1]};
		end else if (cmd.div_step) begin
			p_q <= {p_q[65:0], 1'b0};
		end
		if (cmd.div_load) begin
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (rs >= {1'b0, dvs_q}) begin
				rem_q <= 33'(rs - {1'b0, dvs_q});
				quo_q <= {quo_q[64:0], 1'b1};
			end else begin
				rem_q <= rs[32:0];
				quo_q <= {quo_q[64:0], 1'b0};
			end
		end
	end

	// Form and clip the correction
	always_ff @(posedge clk) begin
		if (cmd.corr_direct) begin
			corr_q <= lft_q.corr;
			sat_q  <= 1'b0;
		end else if (cmd.corr_from_div) begin
			if (corr_w[42:31] != {12{corr_w[42]}}) begin
				corr_q <= corr_w[42] ? 32'sh8000_0000 : 32'sh7fff_ffff;
				sat_q  <= 1'b1;
			end else begin
				corr_q <= corr_w[31:0];
				sat_q  <= 1'b0;
			end
		end
	end

	// Round, sign and clip the result into the output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.extrapolated <= extra_q;
			if (neg_q) begin
				if (rnd > 34'h8000_0000) begin
					out_q.corrected_value <= 32'sh8000_0000;
					out_q.saturated       <= 1'b1;
				end else begin
					out_q.corrected_value <= 32'(-rnd);
					out_q.saturated       <= sat_q;
				end
			end else begin
				if (rnd > 34'h7fff_ffff) begin
					out_q.corrected_value <= 32'sh7fff_ffff;
					out_q.saturated       <= 1'b1;
				end else begin
					out_q.corrected_value <= rnd[31:0];
					out_q.saturated       <= sat_q;
				end
			end
		end
	end

	assign out_item = out_q;

endmodule

### rtl/core/plgc_ctrl.sv
// Controller: sequences load, search, interpolate and scale for one item
module plgc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  plgc_pkg::in_item_t in_item,
	output logic               out_valid,
	input  logic               out_stall,
	input  logic               cfg_we,
	input  logic [6:0]         cfg_wdata,
	input  plgc_pkg::dp_stat_t stat,
	output plgc_pkg::ctl_cmd_t cmd
);
	import plgc_pkg::*;

	`include "piecewise_linear_gain_correction_macros.svh"

	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_CMP, S_SETUP, S_MUL1, S_DIV, S_CORR, S_GAIN, S_MUL2, S_DONE
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  k_q;
	logic [STEP_W-1:0] cnt_q;
	logic [6:0]        pts_q;
	logic              in_stall_q, out_valid_q;
	logic [CNT_W-1:0]  n_use;
	logic              acc, last_pt, out_free;

	// Clamp the point count to the usable range
	always_comb begin
		if (int'(pts_q) > NUM_POINTS) begin
			n_use = CNT_W'(NUM_POINTS);
		end else if (pts_q < 7'd2) begin
			n_use = CNT_W'(2);
		end else begin
			n_use = CNT_W'(pts_q);
		end
	end

	assign acc      = in_valid && !in_stall_q;
	assign last_pt  = (CNT_W'(k_q) == n_use - CNT_W'(1));
	assign out_free = !out_valid_q || !out_stall;

	// Decode commands from state
	always_comb begin
		cmd = '0;
		cmd.rd_idx = k_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc && int'(in_item.axis) < NUM_AXES) begin
					cmd.wr_en = (in_item.operation == OP_LOAD)
						&& (int'(in_item.point_index) < NUM_POINTS);
					cmd.start = (in_item.operation == OP_CORRECT);
				end
			end
			S_READ: cmd.rd_en = 1'b1;
			S_CMP: begin
				if (k_q == '0) begin
					cmd.take_e0   = 1'b1;
					cmd.take_prev = 1'b1;
				end else begin
					cmd.take_e1   = (k_q == IDX_W'(1));
					cmd.e1_live   = (k_q == IDX_W'(1));
					cmd.seg_first = !stat.seg_hit && stat.below_first;
					cmd.set_seg   = stat.seg_hit || last_pt;
					cmd.take_prev = !(stat.seg_hit || last_pt);
				end
			end
			S_SETUP: begin
				cmd.corr_direct     = stat.den_zero;
				cmd.mul_load_interp = !stat.den_zero;
			end
			S_MUL1: begin
				cmd.mul_step = 1'b1;
				cmd.div_load = (cnt_q == STEP_W'(MUL_STEPS - 1));
			end
			S_DIV:  cmd.div_step      = 1'b1;
			S_CORR: cmd.corr_from_div = 1'b1;
			S_GAIN: cmd.mul_load_gain = 1'b1;
			S_MUL2: cmd.mul_step      = 1'b1;
			S_DONE: cmd.out_load      = out_free;
			default: cmd = '0;
		endcase
	end

	// Hold state, counters, config and handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			cnt_q       <= '0;
			pts_q       <= 7'd64;
			in_stall_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				pts_q <= cfg_wdata;
			end
			// Raise valid on a finished item, drop it once taken
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						k_q        <= '0;
						in_stall_q <= 1'b1;
						state_q    <= S_READ;
					end
				end
				S_READ: state_q <= S_CMP;
				S_CMP: begin
					if (cmd.set_seg) begin
						state_q <= S_SETUP;
					end else begin
						k_q     <= k_q + IDX_W'(1);
						state_q <= S_READ;
					end
				end
				S_SETUP: begin
					cnt_q   <= '0;
					state_q <= stat.den_zero ? S_GAIN : S_MUL1;
				end
				S_MUL1: begin
					if (cnt_q == STEP_W'(MUL_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_DIV;
					end else begin
						cnt_q <= cnt_q + STEP_W'(1);
					end
				end
				S_DIV: begin
					if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= S_CORR;
					end else begin
						cnt_q <= cnt_q + STEP_W'(1);
					end
				end
				S_CORR: state_q <= S_GAIN;
				S_GAIN: begin
					cnt_q   <= '0;
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					if (cnt_q == STEP_W'(MUL_STEPS - 1)) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + STEP_W'(1);
					end
				end
				S_DONE: begin
					if (out_free) begin
						in_stall_q  <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = in_stall_q;
	assign out_valid = out_valid_q;

	`PLGC_ASSERT(a_idle_open, (state_q == S_IDLE) |-> !in_stall_q, "stalled while idle")
	`PLGC_NEVER(a_no_overwrite, cmd.out_load && out_valid_q && out_stall, "result overwritten")
	`PLGC_ASSERT(a_wr_on_accept, cmd.wr_en |-> (state_q == S_IDLE && acc), "stray table write")
	`PLGC_ASSERT(a_k_range, (state_q == S_CMP) |-> (CNT_W'(k_q) < n_use), "search past curve")

endmodule

### rtl/core/piecewise_linear_gain_correction.sv
// Piecewise-linear gain correction, top level
//
// Input channel in_valid/in_stall/in_item: a load item writes one breakpoint
// of the X, Y or Z curve and gives no result; it does not raise in_stall.
// A correct item searches its axis curve one breakpoint at a time, reading
// and comparing each, interpolates the correction with a bit-serial multiply
// and divide, scales the sample with a second serial multiply and gives one
// result on out_valid/out_stall/out_item. A zero-width segment skips the
// interpolating multiply and divide. One correct item is in flight at a
// time; in_stall is held from its acceptance until its result is written.
// Items for axis three are dropped without a result.
// The finished result sits in an output register; the next item is taken
// while it waits, and a held result stalls only the write of the next one.
// cfg_we/cfg_wdata set the number of points in use; the user must write
// them only while the block is idle, as the block does not enforce it.
// Reset (arst_n low) clears control and sets 64 points in use; the curve
// memory is not cleared, so every point must be loaded before it is used.
module piecewise_linear_gain_correction (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  plgc_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output plgc_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic [6:0]          cfg_wdata
);
	import plgc_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	plgc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.stat      (stat),
		.cmd       (cmd)
	);

	plgc_dp u_dp (
		.clk      (clk),
		.in_item  (in_item),
		.cmd      (cmd),
		.stat     (stat),
		.out_item (out_item)
	);

endmodule

### tb/sv/tb.sv
// Testbench for the piecewise-linear gain correction block
module tb;
	import plgc_pkg::*;

	localparam logic [1:0] AXIS_X    = 2'd0;
	localparam logic [1:0] AXIS_Y    = 2'd1;
	localparam logic [1:0] AXIS_NONE = 2'd3;
	localparam int CFG_POINTS  = 0;
	localparam int SETTLE      = 2 * NUM_POINTS + 200;
	localparam int STALL_LIMIT = 5000;
	localparam int RAND_ITEMS  = 1000;

	// Curve fill styles
	localparam int CURVE_SORTED = 0;
	localparam int CURVE_DUPS   = 1;
	localparam int CURVE_JUMBLE = 2;
	localparam int CURVE_WILD   = 3;
	localparam int CURVE_FLAT   = 4;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_item;
	logic      cfg_we = 1'b0;
	logic [6:0] cfg_wdata = '0;

	// Predictor copy of the curves and the register
	logic signed [31:0] curve_field [NUM_AXES][NUM_POINTS];
	logic signed [31:0] curve_corr  [NUM_AXES][NUM_POINTS];
	logic [6:0]         points_used = 7'd64;

	out_item_t expected_results[$];
	int  failures = 0;
	int  n_loads = 0, n_corrected = 0, n_extrap = 0, n_sat = 0, n_cfg = 0;
	bit  sender_gaps = 1'b0;
	bit  receiver_gaps = 1'b0;
	int  hold_request = 0;
	int  quiet_cycles = 0;

	piecewise_linear_gain_correction dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [63:0] magnitude(input longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic int points_effective();
		int n;
		n = points_used;
		if (n > NUM_POINTS) n = NUM_POINTS;
		if (n < 2) n = 2;
		return n;
	endfunction

	// Update the curve copy and compute the result an item causes
	function automatic bit apply_correction(input in_item_t it, output out_item_t r);
		int n, seg, i;
		longint s, f0, f1, c0, c1, corr, num, dc, den, gain, res;
		logic [127:0] prod, quot;
		logic [63:0] m, rounded;
		bit neg, extra, sat;
		r = '0;
		if (it.axis == AXIS_NONE) return 1'b0;
		if (it.operation == OP_LOAD) begin
			curve_field[it.axis][it.point_index] = it.breakpoint_field;
			curve_corr[it.axis][it.point_index] = it.breakpoint_correction;
			return 1'b0;
		end
		n = points_effective();
		s = it.sample_value;
		extra = 1'b0;
		sat = 1'b0;
		seg = n;
		for (i = 0; i + 1 < n; i++) begin
			if (seg == n && curve_field[it.axis][i] <= s && s <= curve_field[it.axis][i+1])
				seg = i;
		end
		if (seg == n) begin
			extra = 1'b1;
			seg = (s < curve_field[it.axis][0]) ? 0 : n - 2;
		end
		f0 = curve_field[it.axis][seg];
		f1 = curve_field[it.axis][seg+1];
		c0 = curve_corr[it.axis][seg];
		c1 = curve_corr[it.axis][seg+1];
		den = f1 - f0;
		if (den == 0) begin
			corr = c0;
		end else begin
			num = s - f0;
			dc = c1 - c0;
			neg = (num < 0) ^ (dc < 0) ^ (den < 0);
			prod = 128'(magnitude(num)) * 128'(magnitude(dc));
			quot = prod / 128'(magnitude(den));
			if (quot > 128'(64'd1 << 40)) quot = 128'(64'd1 << 40);
			corr = neg ? c0 - longint'(quot[63:0]) : c0 + longint'(quot[63:0]);
		end
		if (corr > 64'sd2147483647) begin corr = 64'sd2147483647; sat = 1'b1; end
		if (corr < -64'sd2147483648) begin corr = -64'sd2147483648; sat = 1'b1; end
		gain = (64'sd1 <<< 30) + corr;
		m = magnitude(s) * magnitude(gain);
		rounded = (m + (64'd1 << 29)) >> 30;
		neg = (s < 0) ^ (gain < 0);
		if (it.axis != AXIS_Z) neg = !neg;
		res = neg ? -longint'(rounded) : longint'(rounded);
		if (res > 64'sd2147483647) begin res = 64'sd2147483647; sat = 1'b1; end
		if (res < -64'sd2147483648) begin res = -64'sd2147483648; sat = 1'b1; end
		r.corrected_value = res[31:0];
		r.extrapolated = extra;
		r.saturated = sat;
		return 1'b1;
	endfunction

	// Offer one item, wait for acceptance, then predict; returns on a falling edge
	task automatic send_item(input in_item_t it);
		out_item_t r;
		if (sender_gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (apply_correction(it, r)) expected_results.push_back(r);
		if (it.operation == OP_LOAD) n_loads++;
		@(negedge clk);
	endtask

	task automatic send_load(input logic [1:0] axis, input int idx,
			input logic [31:0] fv, input logic [31:0] cv);
		in_item_t it;
		it = in_item_t'({$urandom, $urandom, $urandom});
		it.operation = OP_LOAD;
		it.axis = axis;
		it.point_index = 6'(idx);
		it.breakpoint_field = fv;
		it.breakpoint_correction = cv;
		send_item(it);
	endtask

	task automatic send_sample(input logic [1:0] axis, input logic [31:0] sv);
		in_item_t it;
		it = in_item_t'({$urandom, $urandom, $urandom});
		it.operation = OP_CORRECT;
		it.axis = axis;
		it.sample_value = sv;
		send_item(it);
	endtask

	// Load a whole curve in one of several shapes
	task automatic load_curve(input logic [1:0] axis, input int style);
		longint fv;
		logic [31:0] cv;
		int i;
		fv = -longint'($urandom_range(0, 32'h4000_0000));
		for (i = 0; i < NUM_POINTS; i++) begin
			case (style)
				CURVE_JUMBLE, CURVE_WILD: begin
					fv = $signed($urandom);
				end
				CURVE_DUPS: begin
					if ($urandom_range(0, 3) != 0) fv += $urandom_range(0, 32'h0200_0000);
				end
				CURVE_FLAT: begin
					if (i != 1) fv += $urandom_range(1, 32'h0100_0000);
				end
				default: begin
					fv += $urandom_range(1, 32'h0200_0000);
				end
			endcase
			if (fv > 64'sd2147483647) fv = 64'sd2147483647;
			if (style == CURVE_WILD)
				cv = $urandom_range(0, 1) ? $urandom : ($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000);
			else
				cv = 32'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
			send_load(axis, i, fv[31:0], cv);
		end
	endtask

	// Pick a sample that lands inside, on, or outside the selected curve
	function automatic logic [31:0] pick_sample(input logic [1:0] axis);
		int n, i;
		longint lo, hi;
		n = points_effective();
		i = $urandom_range(0, n - 2);
		lo = curve_field[axis][i];
		hi = curve_field[axis][i+1];
		if (lo > hi) begin lo = hi; hi = curve_field[axis][i]; end
		case ($urandom_range(0, 9))
			0: return curve_field[axis][i];
			1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			2: return $urandom;
			3: return 32'(curve_field[axis][0] - $urandom_range(0, 4096));
			4: return 32'(curve_field[axis][n-1] + $urandom_range(0, 4096));
			default: return 32'(lo + longint'($urandom) % (hi - lo + 1));
		endcase
	endfunction

	// Drain the block, then write the point count
	task automatic write_points(input logic [6:0] value);
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		points_used = value;
		n_cfg++;
		if (CFG_POINTS != 0) $error("unexpected register index");
	endtask

	task automatic test_curve_setup();
		load_curve(AXIS_X, CURVE_SORTED);
		load_curve(AXIS_Y, CURVE_DUPS);
		load_curve(AXIS_Z, CURVE_FLAT);
	endtask

	// Field extremes, edge breakpoints, flat start, saturating gains, axis three
	task automatic test_directed();
		send_sample(AXIS_X, 32'h8000_0000);
		send_sample(AXIS_Y, 32'h7fff_ffff);
		send_sample(AXIS_Z, 32'h0000_0000);
		send_sample(AXIS_X, curve_field[AXIS_X][0]);
		send_sample(AXIS_X, curve_field[AXIS_X][NUM_POINTS-1]);
		send_sample(AXIS_Y, 32'(curve_field[AXIS_Y][0] - 1));
		send_sample(AXIS_Y, 32'(curve_field[AXIS_Y][NUM_POINTS-1] + 1));
		send_sample(AXIS_Z, 32'(curve_field[AXIS_Z][0] - 100));
		send_load(AXIS_NONE, 63, $urandom, $urandom);
		send_sample(AXIS_NONE, $urandom);
		send_load(AXIS_Z, 0, 32'h8000_0000, 32'h7fff_ffff);
		send_load(AXIS_Z, 1, 32'h8000_0000, 32'h8000_0000);
		send_sample(AXIS_Z, 32'h8000_0000);
		send_load(AXIS_Z, 1, 32'h7fff_ffff, 32'h8000_0000);
		send_sample(AXIS_Z, 32'h7fff_0000);
		send_sample(AXIS_X, 32'h8000_0000);
		send_load(AXIS_Z, 0, 32'h8000_0000, 32'h8000_0000);
		send_load(AXIS_Z, 1, 32'h8000_0001, 32'h7fff_ffff);
		send_sample(AXIS_Z, 32'h7fff_ffff);
	endtask

	// Sweep the point count through its extremes, clamped values included
	task automatic test_point_counts();
		logic [6:0] counts[7];
		int k, j;
		counts = '{7'd0, 7'd1, 7'd2, 7'd127, 7'd64, 7'd3, 7'(
			$urandom_range(4, 63))};
		for (k = 0; k < 7; k++) begin
			write_points(counts[k]);
			for (j = 0; j < 6; j++) send_sample(2'($urandom_range(0, 2)),
				pick_sample(2'($urandom_range(0, 2))));
		end
	endtask

	// Hold the receiver off while items keep coming so the block backs up
	task automatic test_backpressure();
		int j;
		hold_request = 400;
		for (j = 0; j < 20; j++) send_sample(AXIS_Z, pick_sample(AXIS_Z));
	endtask

	task automatic test_random();
		int j;
		logic [1:0] axis;
		sender_gaps = 1'b1;
		receiver_gaps = 1'b1;
		for (j = 0; j < RAND_ITEMS; j++) begin
			if (j == RAND_ITEMS - 200) begin
				sender_gaps = 1'b0;
				receiver_gaps = 1'b0;
			end
			if (j % 300 == 150) begin
				write_points(7'($urandom_range(0, 127)));
				load_curve(2'($urandom_range(0, 2)), $urandom_range(CURVE_SORTED, CURVE_FLAT));
			end
			axis = 2'($urandom_range(0, 2));
			case ($urandom_range(0, 19))
				0: send_load(AXIS_NONE, $urandom_range(0, 63), $urandom, $urandom);
				1: send_sample(AXIS_NONE, $urandom);
				2, 3: send_load(axis, $urandom_range(0, 63), $urandom, $urandom);
				default: send_sample(axis, pick_sample(axis));
			endcase
		end
		in_valid <= 1'b0;
	endtask

	// Drive receiver stalls: one long hold on request, otherwise random bursts
	initial begin
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				out_stall <= 1'b1;
				repeat (hold_request - 1) @(negedge clk);
				hold_request = 0;
			end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12) - 1) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result with nothing expected: %h", out_item);
				failures++;
			end else begin
				want = expected_results.pop_front();
				n_corrected++;
				if (out_item.extrapolated) n_extrap++;
				if (out_item.saturated) n_sat++;
				if (out_item.corrected_value !== want.corrected_value) begin
					$error("corrected_value expected %0d actual %0d",
						want.corrected_value, out_item.corrected_value);
					failures++;
				end
				if (out_item.extrapolated !== want.extrapolated) begin
					$error("extrapolated expected %0b actual %0b",
						want.extrapolated, out_item.extrapolated);
					failures++;
				end
				if (out_item.saturated !== want.saturated) begin
					$error("saturated expected %0b actual %0b",
						want.saturated, out_item.saturated);
					failures++;
				end
			end
		end
	end

	// Stop the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_curve_setup();
		test_directed();
		test_point_counts();
		test_backpressure();
		test_random();
		while (expected_results.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		$display("covered %0d loads, %0d corrections (%0d extrapolated, %0d saturated)",
			n_loads, n_corrected, n_extrap, n_sat);
		$display("point count written %0d times; %0d mismatches", n_cfg, failures);
		if (failures == 0 && expected_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
